// File: sv/pdt_pkg.sv
package pdt_pkg;

	localparam int TIME_WIDTH_DEF     = 48;
	localparam int INTERVAL_WIDTH_DEF = 32;

	localparam int CMD_W = 3;

	localparam logic [CMD_W-1:0] CMD_CHECK   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_START   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_STOP    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_RESTART = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SET_IV  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd5;

	localparam int REM_W = 32;
	localparam int IV_IN_W = 32;

	localparam logic [REM_W-1:0] REM_NOT_STARTED = '1;
	localparam logic [REM_W-1:0] REM_SAT         = {1'b0, {(REM_W-1){1'b1}}};

endpackage

// File: sv/periodic_deadline_timer_top.sv
// Command-driven deadline timer. Each command on the input channel carries the current time
// (now); the block answers every command with one result: fired (this check expired the timer),
// running (started flag after the command) and remaining (time to the deadline, saturated at
// 2^31-1, 0 once passed, -1 when stopped). The periodic bit on the config channel selects
// one-shot or periodic rearm; write it only while no command is in flight. Most commands pass
// from IDLE through EXEC to OUT. A check that fires in periodic mode with a nonzero period also
// passes through DIV, RES1 and RES2: the remainder of the elapsed time by the period is found by a
// bit-serial restoring loop that retires one bit of the elapsed time per cycle. One command is
// worked on at a time; a finished result is held in the output register while the next command
// is taken.
module periodic_deadline_timer_top
	import pdt_pkg::*;
#(
	parameter int TIME_WIDTH     = TIME_WIDTH_DEF,
	parameter int INTERVAL_WIDTH = INTERVAL_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic                      cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [CMD_W-1:0]          cmd,
	input  logic [TIME_WIDTH-1:0]     now,
	input  logic signed [IV_IN_W-1:0] new_interval,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      fired,
	output logic                      running,
	output logic signed [REM_W-1:0]   remaining
);

	localparam int TW = TIME_WIDTH;
	localparam int IW = INTERVAL_WIDTH;
	localparam int XW = (IW > IV_IN_W) ? IW : IV_IN_W;
	localparam int CW = $clog2(TW);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_RES1 = 3'd3;
	localparam logic [2:0] S_RES2 = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	localparam logic signed [XW-1:0] IMAX_X = signed'({{(XW-IW+1){1'b0}}, {(IW-1){1'b1}}});
	localparam logic signed [XW-1:0] IMIN_X = ~IMAX_X;

	logic [2:0]           state_q;
	logic [TW-1:0]        deadline_q;
	logic                 started_q;
	logic signed [IW-1:0] period_q;
	logic                 periodic_q;
	logic                 fire_q;

	logic [CMD_W-1:0]     cmd_q;
	logic [TW-1:0]        now_q;
	logic signed [IW-1:0] v_q;
	logic [TW-1:0]        el_q;
	logic [IW-1:0]        r_q;
	logic [CW-1:0]        cnt_q;

	logic signed [XW-1:0] iv_x;
	logic signed [XW-1:0] iv_clamp;
	logic [TW-1:0]        diff;
	logic                 passed;
	logic [63:0]          per64;
	logic [63:0]          v64;
	logic [63:0]          r64;
	logic [63:0]          diff64;
	logic [TW-1:0]        load_p;
	logic [TW-1:0]        load_v;
	logic [IW:0]          div_t;
	logic [IW:0]          div_p;
	logic [IW-1:0]        r_next;
	logic [REM_W-1:0]     rem_word;
	logic                 out_free;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign out_free  = !out_valid || out_ready;

	// clamp the incoming interval to the signed range of the period register
	always_comb begin
		iv_x = XW'(new_interval);
		priority if (iv_x > IMAX_X) begin
			iv_clamp = IMAX_X;
		end else if (iv_x < IMIN_X) begin
			iv_clamp = IMIN_X;
		end else begin
			iv_clamp = iv_x;
		end
	end

	assign diff   = deadline_q - now_q;
	assign passed = (diff == '0) || diff[TW-1];
	assign per64  = 64'($unsigned(period_q));
	assign v64    = 64'($unsigned(v_q));
	assign r64    = 64'(r_q);
	assign load_p = now_q + per64[TW-1:0];
	assign load_v = now_q + v64[TW-1:0];

	// one restoring step of elapsed % period, msb first
	assign div_t  = {r_q, el_q[TW-1]};
	assign div_p  = {1'b0, $unsigned(period_q)};
	assign r_next = (div_t >= div_p) ? IW'(div_t - div_p) : div_t[IW-1:0];

	always_comb begin
		diff64 = 64'(diff);
		priority if (!started_q) begin
			rem_word = REM_NOT_STARTED;
		end else if (passed) begin
			rem_word = '0;
		end else if (|diff64[63:REM_W-1]) begin
			rem_word = REM_SAT;
		end else begin
			rem_word = diff64[REM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			deadline_q <= '0;
			started_q  <= 1'b0;
			period_q   <= '0;
			periodic_q <= 1'b0;
			fire_q     <= 1'b0;
			out_valid  <= 1'b0;
			cnt_q      <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				periodic_q <= cfg_data;
			end
			// in S_OUT the output register is reloaded instead
			if (out_valid && out_ready && state_q != S_OUT) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						fire_q  <= 1'b0;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_OUT;
					unique case (cmd_q)
						CMD_CHECK: begin
							if (started_q && !period_q[IW-1] && passed) begin
								fire_q <= 1'b1;
								if (!periodic_q) begin
									started_q <= 1'b0;
								end else if (period_q == '0) begin
									deadline_q <= now_q;
								end else begin
									cnt_q   <= CW'(TW - 1);
									state_q <= S_DIV;
								end
							end
						end
						CMD_START: begin
							if (!started_q && !period_q[IW-1]) begin
								deadline_q <= load_p;
								started_q  <= 1'b1;
							end
						end
						CMD_STOP: begin
							started_q <= 1'b0;
						end
						CMD_RESTART: begin
							started_q <= !period_q[IW-1];
							if (!period_q[IW-1]) begin
								deadline_q <= load_p;
							end
						end
						CMD_SET_IV: begin
							if (started_q && !v_q[IW-1]) begin
								deadline_q <= load_v;
							end
							period_q <= v_q;
						end
						default: begin
						end
					endcase
				end
				S_DIV: begin
					if (cnt_q == '0) begin
						state_q <= S_RES1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_RES1: begin
					state_q <= S_RES2;
				end
				S_RES2: begin
					deadline_q <= now_q + r64[TW-1:0];
					state_q    <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload and datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			cmd_q <= cmd;
			now_q <= now;
			v_q   <= IW'(iv_clamp);
		end
		if (state_q == S_EXEC) begin
			el_q <= now_q - deadline_q;
			r_q  <= '0;
		end
		if (state_q == S_DIV) begin
			r_q  <= r_next;
			el_q <= el_q << 1;
		end
		if (state_q == S_RES1) begin
			// distance from now to the next grid point
			r_q <= $unsigned(period_q) - r_q;
		end
		if (state_q == S_OUT && out_free) begin
			fired     <= fire_q;
			running   <= started_q;
			remaining <= rem_word;
		end
	end

`ifndef SYNTHESIS
	a_rem_below_period: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> r_q < $unsigned(period_q))
		else $error("remainder not below period during division");

	a_oneshot_stops: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fired && !periodic_q |-> !running)
		else $error("one-shot firing left the timer running");

	a_stopped_rem: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !running |-> remaining == REM_NOT_STARTED)
		else $error("stopped timer reports a remaining time");

	a_div_to_res: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV && cnt_q == '0 |=> state_q == S_RES1)
		else $error("division did not end after the last bit");
`endif

endmodule

// File: tb/sv/periodic_deadline_timer_top_tb.sv
module periodic_deadline_timer_top_tb;
	import pdt_pkg::*;

	localparam int TW = TIME_WIDTH_DEF;
	localparam int LIMIT = 2_000_000;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_ITEMS = 250;
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
	localparam logic [TW-1:0] TIME_TOP = '1;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [TW-1:0]      stamp;
		logic [IV_IN_W-1:0] interval;
	} timer_cmd_t;

	typedef struct packed {
		logic             fired;
		logic             running;
		logic [REM_W-1:0] remaining;
	} timer_result_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic                      cfg_data = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic [CMD_W-1:0]          cmd = '0;
	logic [TW-1:0]             now = '0;
	logic signed [IV_IN_W-1:0] new_interval = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic                      fired;
	logic                      running;
	logic signed [REM_W-1:0]   remaining;

	timer_cmd_t    pending_cmds[$];
	timer_result_t expected_results[$];
	timer_cmd_t    bus_cmd;
	timer_result_t head_result;

	// timer state as the block should hold it
	logic [TW-1:0]      tmr_deadline = '0;
	logic               tmr_started = 1'b0;
	logic signed [31:0] tmr_period = '0;
	logic               periodic_mode = 1'b0;

	int          errors = 0;
	int unsigned cycle_count = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	logic [TW-1:0] time_base = '0;

	periodic_deadline_timer_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.now          (now),
		.new_interval (new_interval),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.fired        (fired),
		.running      (running),
		.remaining    (remaining)
	);

	always #2 clk = ~clk;

	// wrap-aware: passed when deadline - now is zero or negative mod 2^TW
	function automatic logic deadline_passed(input logic [TW-1:0] t);
		logic [TW-1:0] gap;
		gap = tmr_deadline - t;
		return (gap == '0) || gap[TW-1];
	endfunction

	function automatic timer_result_t timer_predict(input timer_cmd_t it);
		timer_result_t res;
		logic signed [31:0] iv;
		logic [TW-1:0] p;
		logic [TW-1:0] elapsed;
		logic [TW-1:0] gap;
		iv = it.interval;
		res.fired = 1'b0;
		case (it.cmd)
			CMD_CHECK: begin
				if (tmr_started && tmr_period >= 0 && deadline_passed(it.stamp)) begin
					res.fired = 1'b1;
					if (!periodic_mode) begin
						tmr_started = 1'b0;
					end else if (tmr_period > 0) begin
						// skip every missed period: first grid point after now
						p = {{(TW-32){1'b0}}, tmr_period};
						elapsed = it.stamp - tmr_deadline;
						tmr_deadline = it.stamp + (p - (elapsed % p));
					end else begin
						tmr_deadline = it.stamp;
					end
				end
			end
			CMD_START: begin
				if (!tmr_started && tmr_period >= 0) begin
					tmr_deadline = it.stamp + {{(TW-32){1'b0}}, tmr_period};
					tmr_started = 1'b1;
				end
			end
			CMD_STOP: tmr_started = 1'b0;
			CMD_RESTART: begin
				tmr_started = 1'b0;
				if (tmr_period >= 0) begin
					tmr_deadline = it.stamp + {{(TW-32){1'b0}}, tmr_period};
					tmr_started = 1'b1;
				end
			end
			CMD_SET_IV: begin
				if (tmr_started && iv >= 0)
					tmr_deadline = it.stamp + {{(TW-32){1'b0}}, iv};
				tmr_period = iv;
			end
			default: ;
		endcase
		res.running = tmr_started;
		gap = tmr_deadline - it.stamp;
		if (!tmr_started)
			res.remaining = REM_NOT_STARTED;
		else if (deadline_passed(it.stamp))
			res.remaining = '0;
		else if (gap > {{(TW-REM_W){1'b0}}, REM_SAT})
			res.remaining = REM_SAT;
		else
			res.remaining = gap[REM_W-1:0];
		return res;
	endfunction

	task automatic add_cmd(input logic [CMD_W-1:0] c, input logic [TW-1:0] t,
			input logic [IV_IN_W-1:0] iv);
		timer_cmd_t it;
		it.cmd = c;
		it.stamp = t;
		it.interval = iv;
		pending_cmds.push_back(it);
	endtask

	function automatic timer_cmd_t random_cmd();
		timer_cmd_t it;
		int unsigned r;
		r = $urandom_range(99);
		if (r < 35)
			it.cmd = CMD_CHECK;
		else if (r < 45)
			it.cmd = CMD_START;
		else if (r < 51)
			it.cmd = CMD_STOP;
		else if (r < 61)
			it.cmd = CMD_RESTART;
		else if (r < 78)
			it.cmd = CMD_SET_IV;
		else if (r < 95)
			it.cmd = CMD_QUERY;
		else
			it.cmd = $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
		// time mostly creeps forward so deadlines are reached; jumps now and then
		r = $urandom_range(99);
		if (r < 4)
			time_base = TW'({$urandom, $urandom});
		else if (r < 7)
			time_base = TIME_TOP - TW'($urandom_range(200));
		else if (r < 10)
			time_base = time_base - TW'($urandom_range(30));
		else
			time_base = time_base + TW'($urandom_range(40));
		it.stamp = time_base;
		r = $urandom_range(99);
		if (r < 40)
			it.interval = $urandom_range(60);
		else if (r < 48)
			it.interval = '0;
		else if (r < 58)
			it.interval = 32'(0) - 32'($urandom_range(1, 100));
		else if (r < 70)
			it.interval = $urandom;
		else if (r < 80)
			it.interval = {1'b0, {(IV_IN_W-1){1'b1}}} - 32'($urandom_range(100));
		else
			it.interval = $urandom_range(5000);
		return it;
	endfunction

	task automatic write_periodic(input logic val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		periodic_mode = val;
		cfg_valid <= 1'b0;
	endtask

	// sender holds off here until every expected result has come back
	task automatic drain_all();
		while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	// command driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_results.push_back(timer_predict(bus_cmd));
			if (!in_valid || in_ready) begin
				if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					bus_cmd = pending_cmds.pop_front();
					in_valid <= 1'b1;
					cmd <= bus_cmd.cmd;
					now <= bus_cmd.stamp;
					new_interval <= bus_cmd.interval;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result with none expected: fired %0b running %0b remaining %0d",
					$time, fired, running, remaining);
				errors++;
			end else begin
				head_result = expected_results.pop_front();
				if (fired !== head_result.fired) begin
					$display("%0t: fired expected %0b actual %0b",
						$time, head_result.fired, fired);
					errors++;
				end
				if (running !== head_result.running) begin
					$display("%0t: running expected %0b actual %0b",
						$time, head_result.running, running);
					errors++;
				end
				if (remaining !== head_result.remaining) begin
					$display("%0t: remaining expected %0d actual %0d", $time,
						$signed(head_result.remaining), remaining);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-shot corners
		write_periodic(1'b0);
		add_cmd(CMD_QUERY, '0, '0);
		add_cmd(CMD_SET_IV, '0, {1'b0, {(IV_IN_W-1){1'b1}}});
		add_cmd(CMD_START, '0, '0);
		add_cmd(CMD_QUERY, TIME_TOP - 4, '0);
		add_cmd(CMD_CHECK, 48'd100, '0);
		add_cmd(CMD_SET_IV, 48'd100, {1'b1, {(IV_IN_W-1){1'b0}}});
		add_cmd(CMD_CHECK, 48'h7FFF_FFFF_FFFF, '0);
		add_cmd(CMD_START, 48'd5, '0);
		add_cmd(CMD_STOP, 48'd5, '1);
		add_cmd(CMD_RESTART, 48'd6, '0);
		add_cmd(CMD_SET_IV, TIME_TOP - 5, 32'd10);
		add_cmd(CMD_RESTART, TIME_TOP - 5, '0);
		add_cmd(CMD_CHECK, 48'd3, '0);
		add_cmd(CMD_CHECK, 48'd4, '0);
		add_cmd(CMD_SPARE_LO, 48'd4, '1);
		add_cmd(CMD_START, 48'd8, '0);
		add_cmd(CMD_START, 48'd9, '0);
		add_cmd(CMD_SPARE_HI, 48'd10, '0);
		drain_all();

		// periodic corners: zero period, catch-up, wrap at the top of time
		write_periodic(1'b1);
		add_cmd(CMD_SET_IV, 48'd100, '0);
		add_cmd(CMD_RESTART, 48'd100, '0);
		add_cmd(CMD_CHECK, 48'd100, '0);
		add_cmd(CMD_CHECK, 48'd100, '0);
		add_cmd(CMD_SET_IV, 48'd200, 32'd7);
		add_cmd(CMD_CHECK, 48'd250, '0);
		add_cmd(CMD_QUERY, 48'd255, '0);
		add_cmd(CMD_SET_IV, TIME_TOP - 2, 32'd3);
		add_cmd(CMD_CHECK, TIME_TOP, '0);
		drain_all();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			write_periodic(ph[0]);
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 87; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 87; end
				default: begin send_idle_pct = 29; recv_stall_pct = 29; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++)
				pending_cmds.push_back(random_cmd());
			drain_all();
		end

		// catch stray results after the last transfer
		repeat (TW + 16) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
